>>> src/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

	// Fixed widths, sized for the largest legal geometry
	localparam int LAT_W  = 13;   // latched sector size, up to 4096
	localparam int POS_W  = 12;   // byte position inside a sector
	localparam int TAB_W  = 17;   // entry array bytes, up to 128 * 512
	localparam int DIV_W  = 18;   // array bytes plus sector size minus one
	localparam int SECT_W = 8;    // array sectors, up to 128
	localparam int OFF_W  = 10;   // byte offset inside one entry
	localparam int ENT_AW = 7;    // entry index
	localparam int ENT_CW = 8;    // entry count
	localparam int ENT_DW = 384;  // stored entry: two GUIDs, first and last LBA

	// Scan phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MBR  = 2'd1;
	localparam logic [1:0] PH_HDR  = 2'd2;
	localparam logic [1:0] PH_TAB  = 2'd3;

	// Input word kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_FAIL  = 2'd2;

	// Result word kinds
	localparam logic [1:0] RK_RECORD  = 2'd0;
	localparam logic [1:0] RK_REQUEST = 2'd1;
	localparam logic [1:0] RK_STATUS  = 2'd2;

	// Table schemes
	localparam logic [1:0] SCH_NONE = 2'd0;
	localparam logic [1:0] SCH_MBR  = 2'd1;
	localparam logic [1:0] SCH_GPT  = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_ARG  = 3'd1;
	localparam logic [2:0] ST_IO   = 3'd2;
	localparam logic [2:0] ST_MBR  = 3'd3;
	localparam logic [2:0] ST_GPT  = 3'd4;
	localparam logic [2:0] ST_MANY = 3'd5;

	// Job codes passed from the front to the back
	localparam logic [2:0] JOB_REQ    = 3'd0;
	localparam logic [2:0] JOB_STATUS = 3'd1;
	localparam logic [2:0] JOB_START  = 3'd2;
	localparam logic [2:0] JOB_MBR    = 3'd3;
	localparam logic [2:0] JOB_HDR    = 3'd4;
	localparam logic [2:0] JOB_TAB    = 3'd5;

	localparam logic [31:0]      CRC_POLY   = 32'hEDB8_8320;
	localparam logic [15:0]      BOOT_SIG   = 16'hAA55;
	localparam logic [7:0]       PROT_TYPE  = 8'hEE;
	localparam logic [7:0]       BOOT_FLAG  = 8'h80;
	localparam logic [31:0]      HDR_MIN    = 32'd92;
	localparam logic [31:0]      ENTRY_MIN  = 32'd128;
	localparam logic [15:0]      SECTOR_MIN = 16'd512;
	localparam logic [POS_W-1:0] MBR_BASE   = 12'd446;
	localparam logic [POS_W-1:0] SIG_LO_POS = 12'd510;
	localparam logic [POS_W-1:0] SIG_HI_POS = 12'd511;
	// "EFI PART", first character in the low byte
	localparam logic [63:0]      EFI_SIG    = 64'h5452_4150_2049_4645;

	typedef struct packed {
		logic [2:0]  code;
		logic [2:0]  status;
		logic        flag;
		logic [63:0] lba;
	} job_t;

	typedef struct packed {
		logic              we;
		logic [ENT_AW-1:0] addr;
		logic [ENT_DW-1:0] data;
	} ent_wr_t;

	typedef struct packed {
		logic [3:0][127:0] slots;
		logic              sig_ok;
		logic [31:0]       hdr_len;
		logic [31:0]       hdr_crc;
		logic [31:0]       run_crc;
		logic [63:0]       hdr_lba;
		logic [63:0]       usable_first;
		logic [63:0]       usable_last;
		logic [63:0]       array_lba;
		logic [31:0]       entries;
		logic [31:0]       entry_bytes;
		logic [LAT_W-1:0]  lat_sector;
		logic [63:0]       lat_device;
	} scan_info_t;

	typedef struct packed {
		logic              go;
		logic [SECT_W-1:0] sectors;
		logic [TAB_W-1:0]  table_bytes;
	} tab_go_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] lba;
		logic [63:0] total;
		logic [63:0] tgl;
		logic [63:0] tgh;
		logic [63:0] ugl;
		logic [63:0] ugh;
		logic [7:0]  mtype;
		logic        boot;
		logic [1:0]  scheme;
		logic [2:0]  status;
		logic        last;
	} res_t;

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
		end
		return r;
	endfunction

	function automatic res_t res_status(input logic [1:0] sch, input logic [2:0] st);
		res_t r;
		r = '0;
		r.kind = RK_STATUS;
		r.scheme = sch;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic res_t res_request(input logic [63:0] lba);
		res_t r;
		r = '0;
		r.kind = RK_REQUEST;
		r.lba = lba;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/pts_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pts_front import pts_pkg::*; #(
	parameter int MAX_SECTOR_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_acc,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire tab_go_t     tab_go,
	output logic             push,
	output job_t             job,
	output scan_info_t       info,
	output ent_wr_t          ent_wr
);

	logic [15:0]       sb_q;
	logic [63:0]       ds_q;
	logic [1:0]        phase_q;
	logic [POS_W-1:0]  pos_q;
	logic [LAT_W-1:0]  lat_sec_q;
	logic [63:0]       lat_dev_q;
	logic [3:0][127:0] slot_q;
	logic [15:0]       bsig_q;
	logic [31:0]       crc_q;
	logic              sig_ok_q;
	logic [31:0]       hlen_q, hcrc_q, ents_q, eb_q, acrc_q;
	logic [63:0]       hlba_q, uf_q, ul_q, alba_q;
	logic [TAB_W-1:0]  tab_total_q, tab_cnt_q;
	logic [OFF_W-1:0]  off_q;
	logic [ENT_AW-1:0] eidx_q;
	logic [ENT_DW-1:0] asm_q;
	logic [SECT_W-1:0] sleft_q;
	logic [63:0]       req_lba_q;

	logic              is_byte, end_sec, start_bad, has_ee, hdr_zero, hdr_crc_en;
	logic              tab_take, entry_end;
	logic [31:0]       crc_hdr_n, crc_tab_n, crc_tab_sel;
	logic [15:0]       bsig_n;
	logic [ENT_DW-1:0] asm_n;
	logic [POS_W-1:0]  mbr_off;

	assign is_byte   = in_acc && (kind == KIND_BYTE) && (phase_q != PH_IDLE);
	assign end_sec   = ({1'b0, pos_q} + 13'd1) >= lat_sec_q;
	assign start_bad = (sb_q < SECTOR_MIN) || (sb_q > 16'(MAX_SECTOR_BYTES)) || (ds_q < 64'd2);
	assign has_ee    = (slot_q[0][39:32] == PROT_TYPE) || (slot_q[1][39:32] == PROT_TYPE) ||
	                   (slot_q[2][39:32] == PROT_TYPE) || (slot_q[3][39:32] == PROT_TYPE);
	assign mbr_off   = pos_q - MBR_BASE;

	// Header CRC: its own CRC field counts as zero
	assign hdr_zero   = (pos_q >= 12'd16) && (pos_q < 12'd20);
	assign hdr_crc_en = (pos_q < 12'd16) || ({20'd0, pos_q} < hlen_q);
	assign crc_hdr_n  = crc_byte(crc_q, hdr_zero ? 8'd0 : data_byte);

	// Entry array bytes
	assign tab_take    = tab_cnt_q < tab_total_q;
	assign crc_tab_n   = crc_byte(crc_q, data_byte);
	assign crc_tab_sel = tab_take ? crc_tab_n : crc_q;
	assign entry_end   = (off_q + 10'd1) == eb_q[OFF_W-1:0];

	always_comb begin
		bsig_n = bsig_q;
		if (pos_q == SIG_LO_POS) begin
			bsig_n[7:0] = data_byte;
		end else if (pos_q == SIG_HI_POS) begin
			bsig_n[15:8] = data_byte;
		end
	end

	// Entry assembly, cleared on the first byte of each entry
	always_comb begin
		asm_n = (off_q == '0) ? '0 : asm_q;
		if (off_q < 10'd48) begin
			asm_n[off_q[5:0]*8 +: 8] = data_byte;
		end
	end

	assign ent_wr.we   = is_byte && (phase_q == PH_TAB) && tab_take && entry_end;
	assign ent_wr.addr = eidx_q;
	assign ent_wr.data = asm_n;

	assign info.slots        = slot_q;
	assign info.sig_ok       = sig_ok_q;
	assign info.hdr_len      = hlen_q;
	assign info.hdr_crc      = hcrc_q;
	assign info.run_crc      = crc_q;
	assign info.hdr_lba      = hlba_q;
	assign info.usable_first = uf_q;
	assign info.usable_last  = ul_q;
	assign info.array_lba    = alba_q;
	assign info.entries      = ents_q;
	assign info.entry_bytes  = eb_q;
	assign info.lat_sector   = lat_sec_q;
	assign info.lat_device   = lat_dev_q;

	// Job for the back end
	always_comb begin
		push = 1'b0;
		job  = '0;
		if (in_acc && (kind == KIND_START)) begin
			push     = 1'b1;
			job.code = JOB_START;
			job.flag = start_bad;
		end else if (in_acc && (kind == KIND_FAIL) && (phase_q != PH_IDLE)) begin
			push       = 1'b1;
			job.code   = JOB_STATUS;
			job.status = ST_IO;
		end else if (is_byte && end_sec) begin
			push = 1'b1;
			case (phase_q)
				PH_MBR: begin
					if (bsig_n != BOOT_SIG) begin
						job.code   = JOB_STATUS;
						job.status = ST_MBR;
					end else if (has_ee) begin
						job.code = JOB_REQ;
						job.lba  = 64'd1;
					end else begin
						job.code = JOB_MBR;
					end
				end
				PH_HDR: job.code = JOB_HDR;
				default: begin
					if (sleft_q > 8'd1) begin
						job.code = JOB_REQ;
						job.lba  = req_lba_q + 64'd1;
					end else begin
						job.code = JOB_TAB;
						job.flag = (~crc_tab_sel == acrc_q);
					end
				end
			endcase
		end
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q        <= 16'd512;
			ds_q        <= 64'd2;
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			lat_sec_q   <= 13'd512;
			lat_dev_q   <= 64'd2;
			bsig_q      <= '0;
			crc_q       <= '1;
			sig_ok_q    <= 1'b0;
			hlen_q      <= '0;
			hcrc_q      <= '0;
			hlba_q      <= '0;
			uf_q        <= '0;
			ul_q        <= '0;
			alba_q      <= '0;
			ents_q      <= '0;
			eb_q        <= '0;
			acrc_q      <= '0;
			tab_total_q <= '0;
			tab_cnt_q   <= '0;
			off_q       <= '0;
			eidx_q      <= '0;
			sleft_q     <= '0;
			req_lba_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index) begin
					ds_q <= cfg_data;
				end else begin
					sb_q <= cfg_data[15:0];
				end
			end

			if (tab_go.go) begin
				phase_q     <= PH_TAB;
				pos_q       <= '0;
				tab_cnt_q   <= '0;
				tab_total_q <= tab_go.table_bytes;
				crc_q       <= '1;
				sleft_q     <= tab_go.sectors;
				off_q       <= '0;
				eidx_q      <= '0;
				req_lba_q   <= alba_q;
			end

			if (in_acc && (kind == KIND_START)) begin
				if (start_bad) begin
					phase_q <= PH_IDLE;
				end else begin
					phase_q   <= PH_MBR;
					lat_sec_q <= sb_q[LAT_W-1:0];
					lat_dev_q <= ds_q;
					pos_q     <= '0;
					bsig_q    <= '0;
				end
			end else if (in_acc && (kind == KIND_FAIL) && (phase_q != PH_IDLE)) begin
				phase_q <= PH_IDLE;
			end else if (is_byte) begin
				pos_q <= end_sec ? '0 : pos_q + 12'd1;
				case (phase_q)
					PH_MBR: begin
						bsig_q <= bsig_n;
						if ((pos_q >= MBR_BASE) && (pos_q < SIG_LO_POS)) begin
							slot_q[mbr_off[5:4]][mbr_off[3:0]*8 +: 8] <= data_byte;
						end
						if (end_sec) begin
							if ((bsig_n == BOOT_SIG) && has_ee) begin
								phase_q  <= PH_HDR;
								crc_q    <= '1;
								sig_ok_q <= 1'b1;
								hlen_q   <= '0;
								hcrc_q   <= '0;
								hlba_q   <= '0;
								uf_q     <= '0;
								ul_q     <= '0;
								alba_q   <= '0;
								ents_q   <= '0;
								eb_q     <= '0;
								acrc_q   <= '0;
							end else begin
								phase_q <= PH_IDLE;
							end
						end
					end
					PH_HDR: begin
						if ((pos_q < 12'd8) && (data_byte != EFI_SIG[pos_q[2:0]*8 +: 8])) begin
							sig_ok_q <= 1'b0;
						end
						if (hdr_crc_en) begin
							crc_q <= crc_hdr_n;
						end
						case (pos_q) inside
							[12'd12:12'd15]: hlen_q[pos_q[1:0]*8 +: 8] <= data_byte;
							[12'd16:12'd19]: hcrc_q[pos_q[1:0]*8 +: 8] <= data_byte;
							[12'd24:12'd31]: hlba_q[pos_q[2:0]*8 +: 8] <= data_byte;
							[12'd40:12'd47]: uf_q[pos_q[2:0]*8 +: 8]   <= data_byte;
							[12'd48:12'd55]: ul_q[pos_q[2:0]*8 +: 8]   <= data_byte;
							[12'd72:12'd79]: alba_q[pos_q[2:0]*8 +: 8] <= data_byte;
							[12'd80:12'd83]: ents_q[pos_q[1:0]*8 +: 8] <= data_byte;
							[12'd84:12'd87]: eb_q[pos_q[1:0]*8 +: 8]   <= data_byte;
							[12'd88:12'd91]: acrc_q[pos_q[1:0]*8 +: 8] <= data_byte;
							default: ;
						endcase
						if (end_sec) begin
							phase_q <= PH_IDLE;
						end
					end
					default: begin
						if (tab_take) begin
							crc_q     <= crc_tab_n;
							asm_q     <= asm_n;
							tab_cnt_q <= tab_cnt_q + 17'd1;
							if (entry_end) begin
								off_q  <= '0;
								eidx_q <= eidx_q + 7'd1;
							end else begin
								off_q <= off_q + 10'd1;
							end
						end
						if (end_sec) begin
							if (sleft_q > 8'd1) begin
								sleft_q   <= sleft_q - 8'd1;
								req_lba_q <= req_lba_q + 64'd1;
							end else begin
								sleft_q <= '0;
								phase_q <= PH_IDLE;
							end
						end
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

>>> src/pts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pts_queue import pts_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t din,
	input  wire logic pop,
	output logic      valid,
	output job_t      dout
);

	job_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       do_push, do_pop;

	assign valid   = cnt_q != 2'd0;
	assign dout    = slot_q[rd_q];
	assign do_pop  = pop && valid;
	assign do_push = push && (cnt_q != 2'd2);

	// Two-word job queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule
`default_nettype wire

>>> src/pts_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pts_back import pts_pkg::*; #(
	parameter int MAX_PARTITIONS   = 16,
	parameter int MAX_SECTOR_BYTES = 4096,
	parameter int MAX_ENTRIES      = 128,
	parameter int MAX_ENTRY_BYTES  = 512
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire job_t       q_job,
	input  wire scan_info_t info,
	input  wire ent_wr_t    ent_wr,
	output logic            q_pop,
	output logic            active,
	output tab_go_t         tab_go,
	output logic            res_valid,
	output res_t            res
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int RW = $clog2(MAX_PARTITIONS + 1);

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_RD    = 4'd1;
	localparam logic [3:0] B_LD    = 4'd2;
	localparam logic [3:0] B_CHK   = 4'd3;
	localparam logic [3:0] B_HCHK  = 4'd4;
	localparam logic [3:0] B_HPREP = 4'd5;
	localparam logic [3:0] B_HDIV  = 4'd6;
	localparam logic [3:0] B_HLIM  = 4'd7;
	localparam logic [3:0] B_HFIN  = 4'd8;

	logic [ENT_DW-1:0] ent_mem [MAX_ENTRIES];
	logic [ENT_DW-1:0] rdata_q;

	logic [3:0]        st_q;
	logic              gpt_q;
	logic [ENT_CW-1:0] idx_q;
	logic [1:0]        scheme_q;
	logic [RW-1:0]     rec_q;
	logic [63:0]       first_q, last_q, diff_q;
	logic [255:0]      guid_q;
	logic [7:0]        mtype_q;
	logic              boot_q;
	logic [TAB_W-1:0]  table_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [LAT_W-1:0]  rem_q;
	logic [4:0]        dcnt_q;
	logic              res_valid_q;
	res_t              res_q;

	logic              hdr_bad, fin_bad, skip, err;
	logic [ENT_CW-1:0] limit;
	logic [127:0]      slot;
	logic [63:0]       total;
	logic [LAT_W:0]    rem_sh;
	logic              ge;

	assign q_pop     = (st_q == B_IDLE) && q_valid;
	assign active    = st_q != B_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign limit     = gpt_q ? info.entries[ENT_CW-1:0] : 8'd4;
	assign slot      = info.slots[idx_q[1:0]];

	// Header field checks
	assign hdr_bad = !info.sig_ok || (info.hdr_len < HDR_MIN) ||
	                 (info.hdr_len > {19'd0, info.lat_sector}) ||
	                 (info.hdr_len > 32'(MAX_SECTOR_BYTES)) ||
	                 (~info.run_crc != info.hdr_crc) || (info.hdr_lba != 64'd1) ||
	                 (info.usable_first > info.usable_last) || (info.entries == 32'd0) ||
	                 (info.entries > 32'(MAX_ENTRIES)) || (info.entry_bytes < ENTRY_MIN) ||
	                 (info.entry_bytes > 32'(MAX_ENTRY_BYTES)) ||
	                 (info.entry_bytes[2:0] != 3'd0);

	// Array extent against the device
	assign fin_bad = (info.array_lba >= info.lat_device) || (dvd_q == '0) ||
	                 ({46'd0, dvd_q} > diff_q);

	// One restoring divide step per cycle
	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, info.lat_sector};

	assign tab_go.go          = (st_q == B_HFIN) && !fin_bad;
	assign tab_go.sectors     = dvd_q[SECT_W-1:0];
	assign tab_go.table_bytes = table_q;

	// Record checks
	always_comb begin
		if (gpt_q) begin
			skip  = guid_q[127:0] == 128'd0;
			err   = (first_q > last_q) || (first_q < info.usable_first) ||
			        (last_q > info.usable_last) || (last_q >= info.lat_device);
			total = last_q - first_q + 64'd1;
		end else begin
			skip  = (mtype_q == 8'd0) || (last_q == 64'd0);
			err   = (first_q >= info.lat_device) || (last_q > diff_q);
			total = last_q;
		end
	end

	// Entry store
	always_ff @(posedge clk) begin
		if (ent_wr.we) begin
			ent_mem[ent_wr.addr[AW-1:0]] <= ent_wr.data;
		end
		rdata_q <= ent_mem[idx_q[AW-1:0]];
	end

	// Job sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			gpt_q       <= 1'b0;
			idx_q       <= '0;
			scheme_q    <= SCH_NONE;
			rec_q       <= '0;
			dcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						case (q_job.code)
							JOB_REQ: begin
								res_valid_q <= 1'b1;
								res_q       <= res_request(q_job.lba);
							end
							JOB_STATUS: begin
								res_valid_q <= 1'b1;
								res_q       <= res_status(scheme_q, q_job.status);
							end
							JOB_START: begin
								scheme_q    <= SCH_NONE;
								rec_q       <= '0;
								res_valid_q <= 1'b1;
								res_q       <= q_job.flag ? res_status(SCH_NONE, ST_ARG) :
								               res_request(64'd0);
							end
							JOB_MBR: begin
								scheme_q <= SCH_MBR;
								gpt_q    <= 1'b0;
								idx_q    <= '0;
								st_q     <= B_RD;
							end
							JOB_HDR: st_q <= B_HCHK;
							JOB_TAB: begin
								if (q_job.flag) begin
									scheme_q <= SCH_GPT;
									gpt_q    <= 1'b1;
									idx_q    <= '0;
									st_q     <= B_RD;
								end else begin
									res_valid_q <= 1'b1;
									res_q       <= res_status(scheme_q, ST_GPT);
								end
							end
							default: ;
						endcase
					end
				end
				B_RD: begin
					if (idx_q >= limit) begin
						res_valid_q <= 1'b1;
						res_q       <= res_status(scheme_q, ST_OK);
						st_q        <= B_IDLE;
					end else begin
						st_q <= B_LD;
					end
				end
				B_LD: begin
					if (gpt_q) begin
						guid_q  <= rdata_q[255:0];
						first_q <= rdata_q[319:256];
						last_q  <= rdata_q[383:320];
						mtype_q <= 8'd0;
						boot_q  <= 1'b0;
					end else begin
						guid_q  <= '0;
						first_q <= {32'd0, slot[95:64]};
						last_q  <= {32'd0, slot[127:96]};
						mtype_q <= slot[39:32];
						boot_q  <= slot[7:0] == BOOT_FLAG;
						diff_q  <= info.lat_device - {32'd0, slot[95:64]};
					end
					st_q <= B_CHK;
				end
				B_CHK: begin
					if (skip) begin
						idx_q <= idx_q + 8'd1;
						st_q  <= B_RD;
					end else if (err) begin
						res_valid_q <= 1'b1;
						res_q       <= res_status(scheme_q, gpt_q ? ST_GPT : ST_MBR);
						st_q        <= B_IDLE;
					end else if (rec_q >= RW'(MAX_PARTITIONS)) begin
						res_valid_q <= 1'b1;
						res_q       <= res_status(scheme_q, ST_MANY);
						st_q        <= B_IDLE;
					end else begin
						rec_q        <= rec_q + RW'(1);
						idx_q        <= idx_q + 8'd1;
						res_valid_q  <= 1'b1;
						res_q        <= '0;
						res_q.kind   <= RK_RECORD;
						res_q.lba    <= first_q;
						res_q.total  <= total;
						res_q.tgl    <= guid_q[63:0];
						res_q.tgh    <= guid_q[127:64];
						res_q.ugl    <= guid_q[191:128];
						res_q.ugh    <= guid_q[255:192];
						res_q.mtype  <= mtype_q;
						res_q.boot   <= boot_q;
						res_q.scheme <= scheme_q;
						st_q         <= B_RD;
					end
				end
				B_HCHK: begin
					if (hdr_bad) begin
						res_valid_q <= 1'b1;
						res_q       <= res_status(scheme_q, ST_GPT);
						st_q        <= B_IDLE;
					end else begin
						table_q <= TAB_W'(info.entries[ENT_CW-1:0] * info.entry_bytes[OFF_W-1:0]);
						st_q    <= B_HPREP;
					end
				end
				B_HPREP: begin
					dvd_q  <= {1'b0, table_q} + {5'd0, info.lat_sector} - 18'd1;
					rem_q  <= '0;
					dcnt_q <= 5'(DIV_W);
					st_q   <= B_HDIV;
				end
				B_HDIV: begin
					rem_q  <= ge ? LAT_W'(rem_sh - {1'b0, info.lat_sector}) : rem_sh[LAT_W-1:0];
					dvd_q  <= {dvd_q[DIV_W-2:0], ge};
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == 5'd1) begin
						st_q <= B_HLIM;
					end
				end
				B_HLIM: begin
					diff_q <= info.lat_device - info.array_lba;
					st_q   <= B_HFIN;
				end
				B_HFIN: begin
					res_valid_q <= 1'b1;
					res_q       <= fin_bad ? res_status(scheme_q, ST_GPT) :
					               res_request(info.array_lba);
					st_q        <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/partition_table_scanner.sv
// Channel   | Signals                                   | Word accepted
// ----------+-------------------------------------------+--------------------------------
// input     | start, busy, kind, data_byte              | rising edge, start & !busy
// config    | cfg_we, cfg_index, cfg_data               | rising edge, cfg_we
// result    | result_valid, result_kind .. last         | edge ending the strobe cycle
//
// Sector bytes stream at one per cycle while busy is low.
// Words that end a sector hold busy while the back end works: on a request or
// status, on a table listing of every MBR slot or GPT entry, and on the header
// checks, which run the sector-count divider.
// Reset is asynchronous and leaves the block idle with 512-byte sectors, 2 sectors.
// Results cannot be stalled; each is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none
module partition_table_scanner import pts_pkg::*; #(
	parameter int MAX_PARTITIONS   = 16,
	parameter int MAX_SECTOR_BYTES = 4096,
	parameter int MAX_ENTRIES      = 128,
	parameter int MAX_ENTRY_BYTES  = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic [63:0]      lba,
	output logic [63:0]      sector_total,
	output logic [63:0]      type_guid_low,
	output logic [63:0]      type_guid_high,
	output logic [63:0]      unique_guid_low,
	output logic [63:0]      unique_guid_high,
	output logic [7:0]       mbr_type,
	output logic             bootable,
	output logic [1:0]       table_scheme,
	output logic [2:0]       status,
	output logic             last
);

	logic       in_acc, push, q_valid, q_pop, back_active;
	job_t       push_job, q_job;
	scan_info_t info;
	ent_wr_t    ent_wr;
	tab_go_t    tab_go;
	res_t       res;

	assign busy   = q_valid || back_active;
	assign in_acc = start && !busy;

	pts_front #(
		.MAX_SECTOR_BYTES(MAX_SECTOR_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.kind     (kind),
		.data_byte(data_byte),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.tab_go   (tab_go),
		.push     (push),
		.job      (push_job),
		.info     (info),
		.ent_wr   (ent_wr)
	);

	pts_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_job),
		.pop   (q_pop),
		.valid (q_valid),
		.dout  (q_job)
	);

	pts_back #(
		.MAX_PARTITIONS  (MAX_PARTITIONS),
		.MAX_SECTOR_BYTES(MAX_SECTOR_BYTES),
		.MAX_ENTRIES     (MAX_ENTRIES),
		.MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.info     (info),
		.ent_wr   (ent_wr),
		.q_pop    (q_pop),
		.active   (back_active),
		.tab_go   (tab_go),
		.res_valid(result_valid),
		.res      (res)
	);

	// Result word fields
	assign result_kind      = res.kind;
	assign lba              = res.lba;
	assign sector_total     = res.total;
	assign type_guid_low    = res.tgl;
	assign type_guid_high   = res.tgh;
	assign unique_guid_low  = res.ugl;
	assign unique_guid_high = res.ugh;
	assign mbr_type         = res.mtype;
	assign bootable         = res.boot;
	assign table_scheme     = res.scheme;
	assign status           = res.status;
	assign last             = res.last;

endmodule
`default_nettype wire

>>> bench/pts_checker.sv
`timescale 1ns / 1ps
module pts_checker import pts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        result_valid,
	input  logic [1:0]  result_kind,
	input  logic [63:0] lba,
	input  logic [63:0] sector_total,
	input  logic [63:0] type_guid_low,
	input  logic [63:0] type_guid_high,
	input  logic [63:0] unique_guid_low,
	input  logic [63:0] unique_guid_high,
	input  logic [7:0]  mbr_type,
	input  logic        bootable,
	input  logic [1:0]  table_scheme,
	input  logic [2:0]  status,
	input  logic        last,
	output int          fails,
	output int          pending
);

	localparam int unsigned LIM_PARTS  = 16;
	localparam int unsigned LIM_SECTOR = 4096;
	localparam int unsigned LIM_ENTS   = 128;
	localparam int unsigned LIM_ESZ    = 512;
	localparam logic        REG_SECTOR = 1'b0;
	localparam logic        REG_DEVICE = 1'b1;

	// programmed geometry
	logic [15:0] sec_reg;
	logic [63:0] dev_reg;

	// scan state
	logic [1:0]  phase;
	int unsigned pos, tab_count, sect_left, recs, ent_off, ent_idx;
	logic [31:0] crc, hdr_len, hdr_crc, ents, ent_sz, tab_crc, lat_sec;
	logic [15:0] boot_sig;
	logic [63:0] hdr_lba, use_first, use_last, tab_lba, lat_dev, req_lba;
	logic [7:0]  mbr_bytes [64];
	logic [63:0] ent_first [LIM_ENTS];
	logic [63:0] ent_last [LIM_ENTS];
	logic [63:0] ent_guid [4*LIM_ENTS];
	logic [1:0]  scheme;
	logic        sig_good;

	res_t words_due[$];

	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
		return r;
	endfunction

	task automatic queue_word(input logic [1:0] k, input logic [63:0] l, input logic [63:0] tot,
			input logic [63:0] g0, input logic [63:0] g1, input logic [63:0] g2,
			input logic [63:0] g3, input logic [7:0] mt, input logic bt,
			input logic [2:0] st, input logic lst);
		res_t r;
		r = '0;
		r.kind = k; r.lba = l; r.total = tot;
		r.tgl = g0; r.tgh = g1; r.ugl = g2; r.ugh = g3;
		r.mtype = mt; r.boot = bt;
		r.scheme = (k == RK_REQUEST) ? SCH_NONE : scheme;
		r.status = st; r.last = lst;
		words_due.push_back(r);
	endtask

	task automatic close_scan(input logic [2:0] st);
		phase = PH_IDLE;
		queue_word(RK_STATUS, 0, 0, 0, 0, 0, 0, 0, 0, st, 1'b1);
	endtask

	task automatic request(input logic [63:0] l);
		queue_word(RK_REQUEST, l, 0, 0, 0, 0, 0, 0, 0, ST_OK, 1'b0);
	endtask

	// end of sector 0: signature, protective slot, else MBR listing
	task automatic mbr_done();
		logic [31:0] first, cnt;
		int unsigned b;
		if (boot_sig != BOOT_SIG) begin
			close_scan(ST_MBR);
			return;
		end
		for (int i = 0; i < 4; i++) begin
			if (mbr_bytes[i*16+4] == PROT_TYPE) begin
				phase = PH_HDR; pos = 0; crc = '1; sig_good = 1'b1;
				hdr_len = 0; hdr_crc = 0; hdr_lba = 0; use_first = 0; use_last = 0;
				tab_lba = 0; ents = 0; ent_sz = 0; tab_crc = 0;
				request(64'd1);
				return;
			end
		end
		scheme = SCH_MBR;
		for (int i = 0; i < 4; i++) begin
			b = i * 16;
			first = {mbr_bytes[b+11], mbr_bytes[b+10], mbr_bytes[b+9], mbr_bytes[b+8]};
			cnt = {mbr_bytes[b+15], mbr_bytes[b+14], mbr_bytes[b+13], mbr_bytes[b+12]};
			if (mbr_bytes[b+4] == 0 || cnt == 0) continue;
			if (64'(first) >= lat_dev || 64'(cnt) > lat_dev - 64'(first)) begin
				close_scan(ST_MBR);
				return;
			end
			if (recs >= LIM_PARTS) begin
				close_scan(ST_MANY);
				return;
			end
			recs++;
			queue_word(RK_RECORD, 64'(first), 64'(cnt), 0, 0, 0, 0, mbr_bytes[b+4],
				mbr_bytes[b] == BOOT_FLAG, ST_OK, 1'b0);
		end
		close_scan(ST_OK);
	endtask

	// header checks and array extent
	task automatic header_done();
		logic [31:0] tbytes, nsec;
		if (!sig_good || hdr_len < 92 || hdr_len > lat_sec || hdr_len > LIM_SECTOR ||
				~crc != hdr_crc || hdr_lba != 1 || use_first > use_last || ents == 0 ||
				ents > LIM_ENTS || ent_sz < 128 || ent_sz > LIM_ESZ || ent_sz[2:0] != 0) begin
			close_scan(ST_GPT);
			return;
		end
		tbytes = ents * ent_sz;
		if (tbytes > LIM_ENTS * LIM_ESZ) begin
			close_scan(ST_GPT);
			return;
		end
		nsec = (tbytes + lat_sec - 1) / lat_sec;
		if (tab_lba >= lat_dev || nsec == 0 || 64'(nsec) > lat_dev - tab_lba) begin
			close_scan(ST_GPT);
			return;
		end
		phase = PH_TAB; pos = 0; tab_count = 0; crc = '1; sect_left = nsec;
		ent_off = 0; ent_idx = 0; req_lba = tab_lba;
		request(req_lba);
	endtask

	// entry array CRC, then one record per used entry
	task automatic table_done();
		logic [63:0] f, l;
		if (~crc != tab_crc) begin
			close_scan(ST_GPT);
			return;
		end
		scheme = SCH_GPT;
		for (int unsigned i = 0; i < ents && i < LIM_ENTS; i++) begin
			f = ent_first[i]; l = ent_last[i];
			if ((ent_guid[4*i] | ent_guid[4*i+1]) == 0) continue;
			if (f > l || f < use_first || l > use_last || l >= lat_dev) begin
				close_scan(ST_GPT);
				return;
			end
			if (recs >= LIM_PARTS) begin
				close_scan(ST_MANY);
				return;
			end
			recs++;
			queue_word(RK_RECORD, f, l - f + 1, ent_guid[4*i], ent_guid[4*i+1],
				ent_guid[4*i+2], ent_guid[4*i+3], 0, 0, ST_OK, 1'b0);
		end
		close_scan(ST_OK);
	endtask

	task automatic header_byte(input int unsigned p, input logic [7:0] b);
		if (p < 8 && b != EFI_SIG[8*p +: 8]) sig_good = 1'b0;
		if (p < 16 || p < hdr_len) crc = crc32_step(crc, (p >= 16 && p < 20) ? 8'd0 : b);
		if (p >= 12 && p < 16) hdr_len |= 32'(b) << (8*(p-12));
		else if (p >= 16 && p < 20) hdr_crc |= 32'(b) << (8*(p-16));
		else if (p >= 24 && p < 32) hdr_lba |= 64'(b) << (8*(p-24));
		else if (p >= 40 && p < 48) use_first |= 64'(b) << (8*(p-40));
		else if (p >= 48 && p < 56) use_last |= 64'(b) << (8*(p-48));
		else if (p >= 72 && p < 80) tab_lba |= 64'(b) << (8*(p-72));
		else if (p >= 80 && p < 84) ents |= 32'(b) << (8*(p-80));
		else if (p >= 84 && p < 88) ent_sz |= 32'(b) << (8*(p-84));
		else if (p >= 88 && p < 92) tab_crc |= 32'(b) << (8*(p-88));
	endtask

	task automatic table_byte(input logic [7:0] b);
		int unsigned i;
		i = ent_idx;
		if (tab_count >= ents * ent_sz || i >= LIM_ENTS) return;
		crc = crc32_step(crc, b);
		if (ent_off == 0) begin
			for (int j = 0; j < 4; j++) ent_guid[4*i+j] = 0;
			ent_first[i] = 0; ent_last[i] = 0;
		end
		if (ent_off < 32) ent_guid[4*i + ent_off/8] |= 64'(b) << (8*(ent_off%8));
		else if (ent_off < 40) ent_first[i] |= 64'(b) << (8*(ent_off-32));
		else if (ent_off < 48) ent_last[i] |= 64'(b) << (8*(ent_off-40));
		tab_count++;
		ent_off++;
		if (ent_off >= ent_sz) begin
			ent_off = 0;
			ent_idx++;
		end
	endtask

	// expected results of one accepted input word
	task automatic predict_scan(input logic [1:0] k, input logic [7:0] b);
		int unsigned p;
		if (k == KIND_START) begin
			scheme = SCH_NONE; recs = 0;
			if (sec_reg < SECTOR_MIN || sec_reg > LIM_SECTOR || dev_reg < 2) begin
				close_scan(ST_ARG);
				return;
			end
			lat_sec = 32'(sec_reg); lat_dev = dev_reg;
			phase = PH_MBR; pos = 0; boot_sig = 0;
			request(64'd0);
			return;
		end
		if (phase == PH_IDLE || k == 2'd3) return;
		if (k == KIND_FAIL) begin
			close_scan(ST_IO);
			return;
		end
		p = pos;
		case (phase)
			PH_MBR: begin
				if (p >= 446 && p < 510) mbr_bytes[p-446] = b;
				else if (p == 510) boot_sig[7:0] = b;
				else if (p == 511) boot_sig[15:8] = b;
			end
			PH_HDR: header_byte(p, b);
			default: table_byte(b);
		endcase
		if (p + 1 < lat_sec) begin
			pos = p + 1;
			return;
		end
		pos = 0;
		if (phase == PH_MBR) mbr_done();
		else if (phase == PH_HDR) header_done();
		else if (sect_left > 1) begin
			sect_left--;
			req_lba++;
			request(req_lba);
		end else begin
			sect_left = 0;
			table_done();
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		fails++;
	endtask

	task automatic check_word();
		res_t w;
		if (words_due.size() == 0) begin
			report("unexpected result word, kind", 64'(result_kind), 0);
			return;
		end
		w = words_due.pop_front();
		if (result_kind != w.kind) report("result_kind", 64'(result_kind), 64'(w.kind));
		if (lba != w.lba) report("lba", lba, w.lba);
		if (sector_total != w.total) report("sector_total", sector_total, w.total);
		if (type_guid_low != w.tgl) report("type_guid_low", type_guid_low, w.tgl);
		if (type_guid_high != w.tgh) report("type_guid_high", type_guid_high, w.tgh);
		if (unique_guid_low != w.ugl) report("unique_guid_low", unique_guid_low, w.ugl);
		if (unique_guid_high != w.ugh) report("unique_guid_high", unique_guid_high, w.ugh);
		if (mbr_type != w.mtype) report("mbr_type", 64'(mbr_type), 64'(w.mtype));
		if (bootable != w.boot) report("bootable", 64'(bootable), 64'(w.boot));
		if (table_scheme != w.scheme) report("table_scheme", 64'(table_scheme), 64'(w.scheme));
		if (status != w.status) report("status", 64'(status), 64'(w.status));
		if (last != w.last) report("last", 64'(last), 64'(w.last));
	endtask

	// results first, so a word accepted on this edge cannot match its own result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_reg = 16'd512; dev_reg = 64'd2;
			phase = PH_IDLE; pos = 0; tab_count = 0; crc = '1; boot_sig = 0;
			hdr_len = 0; hdr_crc = 0; hdr_lba = 0; use_first = 0; use_last = 0;
			tab_lba = 0; ents = 0; ent_sz = 0; tab_crc = 0; sect_left = 0; recs = 0;
			scheme = SCH_NONE; sig_good = 1'b0; lat_sec = 512; lat_dev = 2; req_lba = 0;
			ent_off = 0; ent_idx = 0;
			words_due.delete();
			pending = 0;
		end else begin
			if (result_valid) check_word();
			if (start && !busy) predict_scan(kind, data_byte);
			if (cfg_we) begin
				if (cfg_index == REG_SECTOR) sec_reg = cfg_data[15:0];
				else dev_reg = cfg_data;
			end
			pending = words_due.size();
		end
	end

	initial fails = 0;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
	import pts_pkg::*;

	localparam logic [1:0] KIND_RSVD  = 2'd3;
	localparam logic       REG_SECTOR = 1'b0;
	localparam logic       REG_DEVICE = 1'b1;
	localparam int         WD_LIMIT   = 6000;

	logic        clk, arst_n, start, busy, cfg_we, cfg_index;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [63:0] cfg_data;
	logic        result_valid, bootable, last;
	logic [1:0]  result_kind, table_scheme;
	logic [2:0]  status;
	logic [7:0]  mbr_type;
	logic [63:0] lba, sector_total, type_guid_low, type_guid_high;
	logic [63:0] unique_guid_low, unique_guid_high;
	int          fails, pending, quiet;
	bit          steady;
	int unsigned cur_sec;
	logic [63:0] cur_dev;
	logic [7:0]  img [0:4095];
	logic [7:0]  tab [0:65535];

	partition_table_scanner u_dut (
		.clk, .arst_n, .start, .busy, .kind, .data_byte, .cfg_we, .cfg_index, .cfg_data,
		.result_valid, .result_kind, .lba, .sector_total, .type_guid_low, .type_guid_high,
		.unique_guid_low, .unique_guid_high, .mbr_type, .bootable, .table_scheme,
		.status, .last
	);

	pts_checker u_chk (
		.clk, .arst_n, .start, .busy, .kind, .data_byte, .cfg_we, .cfg_index, .cfg_data,
		.result_valid, .result_kind, .lba, .sector_total, .type_guid_low, .type_guid_high,
		.unique_guid_low, .unique_guid_high, .mbr_type, .bootable, .table_scheme,
		.status, .last, .fails, .pending
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// watchdog: cycles with no word moving either way
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WD_LIMIT) begin
			$display("FAIL partition_table_scanner");
			$finish;
		end
	end

	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_word(input logic [1:0] k, input logic [7:0] b);
		if (!steady && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		data_byte <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// sector bytes, with the odd read failure thrown in
	task automatic send_img(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3999) == 0) send_word(KIND_FAIL, $urandom);
			send_word(KIND_BYTE, img[i]);
		end
	endtask

	task automatic send_tab(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7999) == 0) send_word(KIND_FAIL, $urandom);
			send_word(KIND_BYTE, tab[i]);
		end
	endtask

	task automatic put_img(input int p, input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) img[p+i] = v[8*i +: 8];
	endtask

	task automatic put_tab(input int p, input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) tab[p+i] = v[8*i +: 8];
	endtask

	// hold off until every expected word is back and the block has settled
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (450) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SECTOR) cur_sec = v[15:0];
		else cur_dev = v;
	endtask

	// one full scan: MBR sector, and for GPT the header and the entry array
	task automatic run_scan(input bit gpt);
		int sl, ee_slot, base, n_ent, esz, tbytes, hlen, nsec, r;
		logic [63:0] uf, ul, f, l;
		logic [31:0] c;
		send_word(KIND_START, $urandom);
		if (cur_sec < 512 || cur_sec > 4096 || cur_dev < 2) begin
			send_word(KIND_BYTE, $urandom);
			return;
		end
		sl = cur_sec;
		for (int i = 0; i < sl; i++) img[i] = $urandom;
		ee_slot = gpt ? $urandom_range(0, 3) : 4;
		for (int s = 0; s < 4; s++) begin
			base = 446 + 16 * s;
			img[base] = $urandom_range(0, 1) ? BOOT_FLAG : 8'($urandom);
			c = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
			if (c[7:0] == PROT_TYPE) c = 32'h0C;
			if (s == ee_slot) c = 32'(PROT_TYPE);
			img[base+4] = c[7:0];
			if ($urandom_range(0, 9) == 0) begin
				put_img(base + 8, rand64(), 8);
			end else begin
				put_img(base + 8, $urandom_range(1, 1000), 4);
				put_img(base + 12, $urandom_range(0, 1000), 4);
			end
		end
		img[510] = 8'h55;
		img[511] = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'hAA;
		send_img(sl);
		if (!gpt) return;

		// entry array
		r = $urandom_range(0, 19);
		n_ent = $urandom_range(1, 8); esz = 128;
		if (r == 0) n_ent = 128;
		else if (r == 1) n_ent = 20;
		else if (r == 2) begin n_ent = 4; esz = 512; end
		else if (r == 3) esz = 136;
		else if (r == 4) esz = 130;
		tbytes = n_ent * esz;
		nsec = (tbytes + sl - 1) / sl;
		uf = $urandom_range(2, 40);
		ul = uf + 200;
		for (int i = 0; i < nsec * sl; i++) tab[i] = (i < tbytes) ? 8'($urandom) : 8'd0;
		for (int e = 0; e < n_ent; e++) begin
			base = e * esz;
			if ($urandom_range(0, 3) == 0) put_tab(base, 0, 8);
			if ($urandom_range(0, 3) == 0) put_tab(base + 8, 0, 8);
			f = uf + $urandom_range(0, 50);
			l = f + $urandom_range(0, 50);
			if ($urandom_range(0, 29) == 0) l = f - 1;
			if ($urandom_range(0, 29) == 0) l = ul + 1;
			put_tab(base + 32, f, 8);
			put_tab(base + 40, l, 8);
		end
		c = '1;
		for (int i = 0; i < tbytes; i++) c = crc32_step(c, tab[i]);
		c = ~c;
		if ($urandom_range(0, 9) == 0) tab[$urandom_range(0, tbytes - 1)] ^= 8'(1 << $urandom_range(0, 7));

		// header
		for (int i = 0; i < sl; i++) img[i] = $urandom;
		hlen = ($urandom_range(0, 5) == 0) ? $urandom_range(92, sl) : 92;
		put_img(0, 64'h5452_4150_2049_4645, 8);
		put_img(12, hlen, 4);
		put_img(16, 0, 4);
		put_img(24, 1, 8);
		put_img(40, uf, 8);
		put_img(48, ul, 8);
		put_img(72, 2, 8);
		put_img(80, n_ent, 4);
		put_img(84, esz, 4);
		put_img(88, c, 4);
		c = '1;
		for (int i = 0; i < hlen; i++) c = crc32_step(c, img[i]);
		put_img(16, ~c, 4);
		if ($urandom_range(0, 7) == 0) img[$urandom_range(0, 91)] ^= 8'(1 << $urandom_range(0, 7));
		send_img(sl);
		send_tab(nsec * sl);
	endtask

	task automatic pick_geometry();
		int r;
		drain();
		r = $urandom_range(0, 19);
		write_reg(REG_SECTOR, r == 0 ? 64'd4096 : r == 1 ? 64'd1024 : r == 2 ? 64'd511 :
			r == 3 ? 64'd4097 : r == 4 ? 64'hFFFF_FFFF_FFFF_0000 : r == 5 ? rand64() : 64'd512);
		r = $urandom_range(0, 19);
		write_reg(REG_DEVICE, r == 0 ? 64'd2 : r == 1 ? 64'd1 : r == 2 ? 64'd0 :
			r == 3 ? '1 : r == 4 ? rand64() : r == 5 ? 64'd40 : 64'd100000);
	endtask

	initial begin
		arst_n = 1'b0; start = 1'b0; kind = KIND_START; data_byte = 0;
		cfg_we = 1'b0; cfg_index = REG_SECTOR; cfg_data = 0; quiet = 0; steady = 1'b0;
		cur_sec = 512; cur_dev = 2;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// words while idle, and the reserved kind, are dropped
		send_word(KIND_BYTE, 8'hFF);
		send_word(KIND_FAIL, 8'h00);
		send_word(KIND_RSVD, 8'hA5);
		// geometry limits
		drain();
		write_reg(REG_SECTOR, 64'd511);
		send_word(KIND_START, 0);
		drain();
		write_reg(REG_SECTOR, 64'd4097);
		send_word(KIND_START, 0);
		drain();
		write_reg(REG_SECTOR, 64'd512);
		write_reg(REG_DEVICE, 64'd1);
		send_word(KIND_START, 0);
		drain();
		write_reg(REG_DEVICE, '1);
		// read failure, restart mid-scan, reserved kind mid-scan
		send_word(KIND_START, 0);
		send_word(KIND_BYTE, 8'h00);
		send_word(KIND_FAIL, 8'hFF);
		send_word(KIND_START, 0);
		send_word(KIND_RSVD, 0);
		send_word(KIND_BYTE, 8'h12);
		run_scan(1'b0);
		run_scan(1'b1);
		drain();
		write_reg(REG_SECTOR, 64'd4096);
		write_reg(REG_DEVICE, 64'd100000);
		run_scan(1'b1);
		run_scan(1'b0);
		drain();
		write_reg(REG_SECTOR, 64'd512);

		// random scans, a no-gap stretch in the middle
		for (int n = 0; n < 70; n++) begin
			steady = (n >= 25 && n < 35);
			if ($urandom_range(0, 4) == 0) pick_geometry();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) send_word($urandom_range(0, 3), $urandom);
			end
			run_scan($urandom_range(0, 9) < 6);
		end
		steady = 1'b0;

		drain();
		if (fails == 0 && pending == 0) begin
			$display("PASS partition_table_scanner");
		end else begin
			$display("FAIL partition_table_scanner");
		end
		$finish;
	end

endmodule
